[hw/rtl/tcas_pkg.sv]
// Shared types, codes and sizes for the scrolling text console.
// Used by tcas_cell_ram and text_console_ansi_strip. No dependencies.
`default_nettype none

package tcas_pkg;

    // Default screen geometry
    localparam int ROWS_DEF = 22;
    localparam int COLS_DEF = 50;

    // Field widths of the stream items
    localparam int CMD_W  = 2;
    localparam int BYTE_W = 8;
    localparam int VROW_W = 5;
    localparam int VCOL_W = 6;

    localparam int S_FIELDS_W = CMD_W + BYTE_W + VROW_W + VCOL_W;
    localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = BYTE_W + VROW_W + VCOL_W + 1;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    typedef logic [CMD_W-1:0]  cmd_t;
    typedef logic [BYTE_W-1:0] byte_t;

    // Commands
    localparam cmd_t CMD_PUT   = 2'd0;
    localparam cmd_t CMD_READ  = 2'd1;
    localparam cmd_t CMD_CLEAR = 2'd2;

    // Escape parser states
    localparam logic [1:0] MODE_TEXT = 2'd0;
    localparam logic [1:0] MODE_ESC  = 2'd1;
    localparam logic [1:0] MODE_CSI  = 2'd2;

    // What the result's character field carries
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_BLANK = 2'd1;
    localparam logic [1:0] KIND_CELL  = 2'd2;

    // Byte codes
    localparam byte_t CH_TAB      = 8'h09;
    localparam byte_t CH_LF       = 8'h0A;
    localparam byte_t CH_CR       = 8'h0D;
    localparam byte_t CH_ESC      = 8'h1B;
    localparam byte_t CH_SPACE    = 8'h20;
    localparam byte_t CH_FINAL_LO = 8'h40;
    localparam byte_t CH_LBRACKET = 8'h5B;
    localparam byte_t CH_FINAL_HI = 8'h7E;

endpackage

`default_nettype wire

[hw/rtl/tcas_cell_ram.sv]
// Character cell store: one write port, one registered read port.
// Depends on tcas_pkg for the default geometry and byte type.
`default_nettype none

module tcas_cell_ram #(
    parameter int ROWS = tcas_pkg::ROWS_DEF,
    parameter int COLS = tcas_pkg::COLS_DEF,
    parameter int AW   = $clog2(ROWS * COLS)
) (
    input  wire                  aclk,
    input  wire                  wr_en,
    input  wire [AW-1:0]         wr_addr,
    input  wire tcas_pkg::byte_t wr_data,
    input  wire                  rd_en,
    input  wire [AW-1:0]         rd_addr,
    output tcas_pkg::byte_t      rd_data
);
    import tcas_pkg::*;

    localparam int DEPTH = ROWS * COLS;

    byte_t mem [DEPTH];
    byte_t rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered; holds while not enabled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[hw/rtl/text_console_ansi_strip.sv]
// Scrolling text console with ANSI escape filtering, top level.
// Depends on tcas_pkg and tcas_cell_ram.
//
// Usage:
//   s_* channel takes one command per transfer: put a stream byte, read a
//   cell of the visible screen, or clear the screen. Every command gives
//   exactly one result transfer on m_*: the character read (0x20 for a
//   never-written cell, 0 for commands other than read), the cursor
//   position after the command and a flag set when the command scrolled.
//   Throughput: one command per cycle while m_* is not stalled. All cursor, scroll and escape state
//   is updated in the cycle of the transfer, so commands follow back to
//   back with no bubbles.
//   Result: registered, on m_* in the cycle after the input transfer; a cell read
//   uses the registered read ports of the cell and row mask memories.
//   Stall: the result register holds until m_tready; s_tready stays high
//   while the result register is empty or being drained this cycle.
//   Reset: cursor, top pointer, escape state and the cursor row's written
//   mask are cleared; the block is ready in the first cycle after reset.
//   Neither memory is cleared: rows below the cursor are always empty and
//   rows above it got their mask stored when the cursor left them.
`default_nettype none

module text_console_ansi_strip #(
    parameter int ROWS = tcas_pkg::ROWS_DEF,
    parameter int COLS = tcas_pkg::COLS_DEF
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    // s_tdata: cmd[1:0], data_byte[9:2], view_row[14:10], view_col[20:15]
    input  wire                            s_tvalid,
    output logic                           s_tready,
    input  wire [tcas_pkg::S_DATA_W-1:0]   s_tdata,
    // m_tdata: cell_char[7:0], cursor_row[12:8], cursor_col[18:13],
    //          scrolled[19]
    output logic                           m_tvalid,
    input  wire                            m_tready,
    output logic [tcas_pkg::M_DATA_W-1:0]  m_tdata
);
    import tcas_pkg::*;

    localparam int RW  = $clog2(ROWS);
    localparam int CW  = $clog2(COLS + 1);
    localparam int CIW = $clog2(COLS);
    localparam int AW  = $clog2(ROWS * COLS);

    // Visible row to physical row through the ring top pointer
    function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] top,
                                               input logic [RW-1:0] vis);
        logic [RW:0] sum;
        begin
            sum = {1'b0, top} + {1'b0, vis};
            if (sum >= (RW+1)'(ROWS)) begin
                sum = sum - (RW+1)'(ROWS);
            end
            return sum[RW-1:0];
        end
    endfunction

    // Input fields
    cmd_t                   in_cmd;
    byte_t                  in_byte;
    logic [VROW_W-1:0]      in_vrow;
    logic [VCOL_W-1:0]      in_vcol;
    logic                   accept;

    assign in_cmd  = s_tdata[CMD_W-1:0];
    assign in_byte = s_tdata[CMD_W+BYTE_W-1:CMD_W];
    assign in_vrow = s_tdata[CMD_W+BYTE_W+VROW_W-1:CMD_W+BYTE_W];
    assign in_vcol = s_tdata[S_FIELDS_W-1:CMD_W+BYTE_W+VROW_W];

    // Console state
    logic [1:0]       mode_reg, mode_next;
    logic [RW-1:0]    row_reg, row_next;
    logic [CW-1:0]    col_reg, col_next;
    logic [RW-1:0]    top_reg, top_next;
    logic [COLS-1:0]  cur_mask_reg, cur_mask_next;

    // Written masks of the rows above the cursor
    logic [COLS-1:0]  mask_mem [ROWS];
    logic [COLS-1:0]  mask_rd_data_reg;
    logic [RW-1:0]    cur_prow;
    logic             mask_wr;

    // Result stage
    logic             out_valid_reg;
    logic [1:0]       out_kind_reg, out_kind_next;
    logic [RW-1:0]    out_row_reg;
    logic [CW-1:0]    out_col_reg;
    logic             out_scr_reg, out_scr_next;
    logic             out_cur_hit_reg, out_cur_hit_next;
    logic             out_mem_sel_reg, out_mem_sel_next;
    logic [CIW-1:0]   out_rd_col_reg;
    byte_t            ram_rd_data;
    byte_t            cell_char;
    logic             cell_hit;

    // Update controls
    logic             do_nl;
    logic             do_wr;
    logic             do_clear;
    logic             scroll;
    logic [RW-1:0]    wr_row;
    logic [CIW-1:0]   wr_col;
    logic [CW:0]      tab_col;
    logic [RW:0]      row_inc;
    logic [AW-1:0]    wr_addr;

    // Read path
    logic             rd_ok;
    logic [RW-1:0]    rd_vis;
    logic [RW-1:0]    rd_row;
    logic [CIW-1:0]   rd_col;
    logic [AW-1:0]    rd_addr;
    logic             rd_en;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Next cursor, scroll and escape state for the command on s_tdata
    always_comb begin
        mode_next = mode_reg;
        row_next  = row_reg;
        col_next  = col_reg;
        top_next  = top_reg;
        do_nl     = 1'b0;
        do_wr     = 1'b0;
        do_clear  = 1'b0;
        scroll    = 1'b0;
        tab_col   = ({1'b0, col_reg} + (CW+1)'(4)) & ~(CW+1)'(3);
        row_inc   = {1'b0, row_reg} + (RW+1)'(1);

        unique case (in_cmd)
            CMD_PUT: begin
                unique case (mode_reg)
                    MODE_CSI: begin
                        if (in_byte >= CH_FINAL_LO && in_byte <= CH_FINAL_HI) begin
                            mode_next = MODE_TEXT;
                        end
                    end
                    MODE_ESC: begin
                        mode_next = (in_byte == CH_LBRACKET) ? MODE_CSI : MODE_TEXT;
                    end
                    default: begin
                        mode_next = MODE_TEXT;
                        if (in_byte == CH_ESC) begin
                            mode_next = MODE_ESC;
                        end else if (in_byte == CH_CR) begin
                            col_next = '0;
                        end else if (in_byte == CH_LF) begin
                            do_nl = 1'b1;
                        end else if (in_byte == CH_TAB) begin
                            if (tab_col >= (CW+1)'(COLS)) begin
                                do_nl = 1'b1;
                            end else begin
                                col_next = tab_col[CW-1:0];
                            end
                        end else if (in_byte >= CH_SPACE) begin
                            do_wr = 1'b1;
                            if (col_reg >= CW'(COLS)) begin
                                do_nl = 1'b1;
                            end
                        end
                    end
                endcase
            end
            CMD_CLEAR: begin
                do_clear = 1'b1;
            end
            default: begin
            end
        endcase

        // New line, scrolling at the bottom row
        if (do_nl) begin
            col_next = '0;
            if (row_inc < (RW+1)'(ROWS)) begin
                row_next = row_inc[RW-1:0];
            end else begin
                scroll   = 1'b1;
                row_next = RW'(ROWS - 1);
                top_next = (top_reg == RW'(ROWS - 1)) ? '0 : RW'(top_reg + 1'b1);
            end
        end

        // Printable byte lands at the cursor after any wrap
        wr_col = do_nl ? '0 : col_reg[CIW-1:0];
        wr_row = phys_row(top_next, row_next);
        if (do_wr) begin
            col_next = CW'(wr_col) + CW'(1);
        end

        if (do_clear) begin
            mode_next = MODE_TEXT;
            row_next  = '0;
            col_next  = '0;
            top_next  = '0;
        end
    end

    // Cursor row mask: a new line always enters an empty row
    always_comb begin
        cur_mask_next = cur_mask_reg;
        if (do_nl || do_clear) begin
            cur_mask_next = '0;
        end
        if (do_wr) begin
            cur_mask_next[wr_col] = 1'b1;
        end
    end

    // The row being left is stored in the mask memory
    assign cur_prow = phys_row(top_reg, row_reg);
    assign mask_wr  = accept && do_nl;

    assign wr_addr = AW'(wr_row) * AW'(COLS) + AW'(wr_col);

    // Cell read lookup
    assign rd_ok   = (32'(in_vrow) < ROWS) && (32'(in_vcol) < COLS);
    assign rd_vis  = RW'(in_vrow);
    assign rd_row  = rd_ok ? phys_row(top_reg, rd_vis) : '0;
    assign rd_col  = rd_ok ? CIW'(in_vcol) : '0;
    assign rd_addr = AW'(rd_row) * AW'(COLS) + AW'(rd_col);
    assign rd_en   = accept && (in_cmd == CMD_READ) && rd_ok;

    // Cursor row mask is in flops, rows above it in memory, rows below empty
    always_comb begin
        out_kind_next = KIND_NONE;
        if (in_cmd == CMD_READ) begin
            out_kind_next = rd_ok ? KIND_CELL : KIND_BLANK;
        end
        out_scr_next     = scroll;
        out_cur_hit_next = (rd_vis == row_reg) && cur_mask_reg[rd_col];
        out_mem_sel_next = (rd_vis < row_reg);
    end

    // Console state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_TEXT;
            row_reg      <= '0;
            col_reg      <= '0;
            top_reg      <= '0;
            cur_mask_reg <= '0;
        end else if (accept) begin
            mode_reg     <= mode_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            top_reg      <= top_next;
            cur_mask_reg <= cur_mask_next;
        end
    end

    // Row mask memory write port
    always_ff @(posedge aclk) begin
        if (mask_wr) begin
            mask_mem[cur_prow] <= cur_mask_reg;
        end
    end

    // Row mask memory read port, registered; holds while not enabled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            mask_rd_data_reg <= mask_mem[rd_row];
        end
    end

    // Result register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_tready) begin
            out_valid_reg <= s_tvalid;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            out_kind_reg    <= out_kind_next;
            out_row_reg     <= row_next;
            out_col_reg     <= col_next;
            out_scr_reg     <= out_scr_next;
            out_cur_hit_reg <= out_cur_hit_next;
            out_mem_sel_reg <= out_mem_sel_next;
            out_rd_col_reg  <= rd_col;
        end
    end

    tcas_cell_ram #(
        .ROWS (ROWS),
        .COLS (COLS),
        .AW   (AW)
    ) u_cell_ram (
        .aclk    (aclk),
        .wr_en   (accept && do_wr),
        .wr_addr (wr_addr),
        .wr_data (in_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    // Character field of the result
    assign cell_hit = out_cur_hit_reg ||
                      (out_mem_sel_reg && mask_rd_data_reg[out_rd_col_reg]);

    always_comb begin
        case (out_kind_reg)
            KIND_CELL:  cell_char = cell_hit ? ram_rd_data : CH_SPACE;
            KIND_BLANK: cell_char = CH_SPACE;
            default:    cell_char = '0;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - M_FIELDS_W){1'b0}},
                       out_scr_reg,
                       VCOL_W'(out_col_reg),
                       VROW_W'(out_row_reg),
                       cell_char};

endmodule

`default_nettype wire
